// File: design/assert_macros.svh
// assertion macros shared by the edge trigger capture design
// no dependencies; take in with an include of the bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ASSERT_IMPL(lbl, clk_s, rstn_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// next-cycle implication, checked outside reset
`define ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

// File: design/etc_pkg.sv
// types and constants of the edge trigger capture block
// used by etc_regs, etc_dp, etc_ctrl and the top level; no dependencies
package etc_pkg;

    localparam int SAMPLE_WIDTH = 16;
    localparam int PADDR_WIDTH  = 5;
    localparam int PDATA_WIDTH  = 32;
    localparam int LEN_WIDTH    = 17;
    localparam int NWIN_WIDTH   = 7;
    localparam int HOLD_WIDTH   = 24;
    localparam int SKIP_WIDTH   = 25;
    localparam int ELAPSED_WIDTH = 33;
    localparam int FRAC_WIDTH   = 16;
    localparam int LEN_FIELD_MAX = 131071;

    localparam logic [16:0] RST_WINDOW_LEN  = 17'd1024;
    localparam logic [6:0]  RST_NUM_WINDOWS = 7'd1;
    localparam logic [23:0] RST_HOLD_OFF    = 24'd1024;
    localparam logic [1:0]  RST_SLOPE       = 2'd0;
    localparam logic [2:0]  RST_MODE        = 3'd0;
    localparam logic [15:0] RST_LEVEL       = 16'd0;
    localparam logic [7:0]  RST_POSITION    = 8'd128;
    localparam logic [31:0] RST_EVENT_TICKS = 32'd1000;

    localparam logic [1:0] SLOPE_RISE  = 2'd0;
    localparam logic [1:0] SLOPE_FALL  = 2'd1;
    localparam logic [1:0] SLOPE_BOTH  = 2'd2;
    localparam logic [1:0] SLOPE_LABEL = 2'd3;

    localparam logic [2:0] MODE_AUTO     = 3'd0;
    localparam logic [2:0] MODE_SEMI     = 3'd1;
    localparam logic [2:0] MODE_NORMAL   = 3'd2;
    localparam logic [2:0] MODE_PERIODIC = 3'd3;

    typedef enum logic [2:0] {
        REG_WINDOW_LEN  = 3'd0,
        REG_NUM_WINDOWS = 3'd1,
        REG_HOLD_OFF    = 3'd2,
        REG_SLOPE       = 3'd3,
        REG_MODE        = 3'd4,
        REG_LEVEL       = 3'd5,
        REG_POSITION    = 3'd6,
        REG_EVENT_TICKS = 3'd7
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_DIV,
        ST_COMMIT,
        ST_OUT
    } etc_state_t;

    typedef struct packed {
        logic              kind;
        logic signed [15:0] sample;
        logic              label_hit;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] out_sample;
        logic              trigger_mark;
        logic [15:0]       fraction;
        logic              first_of_packet;
        logic              last_of_window;
        logic              last_of_packet;
    } out_item_t;

    typedef struct packed {
        logic [16:0]        window_len;
        logic [6:0]         num_windows;
        logic [23:0]        hold_off;
        logic [1:0]         slope_select;
        logic [2:0]         trigger_mode;
        logic signed [15:0] level;
        logic [7:0]         position;
        logic [31:0]        event_ticks;
    } cfg_t;

    typedef struct packed {
        logic        valid;
        logic [23:0] value;
    } hold_wr_t;

    typedef struct packed {
        logic load;
        logic tick;
        logic eval;
        logic div_start;
        logic commit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic need_div;
        logic div_done;
        logic emit;
    } dp_stat_t;

endpackage

// File: design/etc_regs.sv
// configuration register file with apb write and read access
// depends on etc_pkg
module etc_regs
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [etc_pkg::PADDR_WIDTH-1:0] paddr,
    input  logic [etc_pkg::PDATA_WIDTH-1:0] pwdata,
    output logic [etc_pkg::PDATA_WIDTH-1:0] prdata,
    output etc_pkg::cfg_t                   cfg,
    output etc_pkg::hold_wr_t               hold_wr
);

    etc_pkg::cfg_t    cfg_reg;
    etc_pkg::reg_idx_t idx;
    logic             wr_en;

    assign idx   = etc_pkg::reg_idx_t'(paddr[4:2]);
    assign wr_en = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.window_len   <= etc_pkg::RST_WINDOW_LEN;
            cfg_reg.num_windows  <= etc_pkg::RST_NUM_WINDOWS;
            cfg_reg.hold_off     <= etc_pkg::RST_HOLD_OFF;
            cfg_reg.slope_select <= etc_pkg::RST_SLOPE;
            cfg_reg.trigger_mode <= etc_pkg::RST_MODE;
            cfg_reg.level        <= etc_pkg::RST_LEVEL;
            cfg_reg.position     <= etc_pkg::RST_POSITION;
            cfg_reg.event_ticks  <= etc_pkg::RST_EVENT_TICKS;
        end
        else if (wr_en)
        begin
            case (idx)
                etc_pkg::REG_WINDOW_LEN:  cfg_reg.window_len   <= pwdata[16:0];
                etc_pkg::REG_NUM_WINDOWS: cfg_reg.num_windows  <= pwdata[6:0];
                etc_pkg::REG_HOLD_OFF:    cfg_reg.hold_off     <= pwdata[23:0];
                etc_pkg::REG_SLOPE:       cfg_reg.slope_select <= pwdata[1:0];
                etc_pkg::REG_MODE:        cfg_reg.trigger_mode <= pwdata[2:0];
                etc_pkg::REG_LEVEL:       cfg_reg.level        <= pwdata[15:0];
                etc_pkg::REG_POSITION:    cfg_reg.position     <= pwdata[7:0];
                etc_pkg::REG_EVENT_TICKS: cfg_reg.event_ticks  <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            etc_pkg::REG_WINDOW_LEN:  prdata = {15'd0, cfg_reg.window_len};
            etc_pkg::REG_NUM_WINDOWS: prdata = {25'd0, cfg_reg.num_windows};
            etc_pkg::REG_HOLD_OFF:    prdata = {8'd0, cfg_reg.hold_off};
            etc_pkg::REG_SLOPE:       prdata = {30'd0, cfg_reg.slope_select};
            etc_pkg::REG_MODE:        prdata = {29'd0, cfg_reg.trigger_mode};
            etc_pkg::REG_LEVEL:       prdata = {16'd0, cfg_reg.level};
            etc_pkg::REG_POSITION:    prdata = {24'd0, cfg_reg.position};
            etc_pkg::REG_EVENT_TICKS: prdata = cfg_reg.event_ticks;
            default:                  prdata = '0;
        endcase
    end

    assign cfg           = cfg_reg;
    // the datapath clips its hold-off countdown on this write
    assign hold_wr.valid = wr_en && (idx == etc_pkg::REG_HOLD_OFF);
    assign hold_wr.value = pwdata[23:0];

endmodule

// File: design/etc_div.sv
// bit-serial restoring divider for the q0.16 crossing fraction
// depends on nothing outside this file; numerator never exceeds the divisor
module etc_div
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [16:0] num,
    input  logic [16:0] den,
    output logic        done,
    output logic [15:0] quot
);

    localparam logic [4:0] LAST_STEP = 5'd16;

    logic        busy_reg;
    logic        done_reg;
    logic [4:0]  cnt_reg;
    logic [17:0] rem_reg;
    logic [16:0] den_reg;
    logic [16:0] q_reg;
    logic [17:0] rem_try;
    logic        ge;

    // the first step tests the integer bit without a shift
    assign rem_try = (cnt_reg == '0) ? rem_reg : {rem_reg[16:0], 1'b0};
    assign ge      = rem_try >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == LAST_STEP)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= {1'b0, num};
            den_reg <= den;
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? (rem_try - {1'b0, den_reg}) : rem_try;
            q_reg   <= {q_reg[15:0], ge};
        end
    end

    assign done = done_reg;
    assign quot = q_reg[16] ? 16'hFFFF : q_reg[15:0];

endmodule

// File: design/etc_dp.sv
// datapath: history memory, trigger search, window counters, result register
// depends on etc_pkg and etc_div
module etc_dp
#(
    parameter int HIST_DEPTH = 256,
    parameter int MAX_POINTS = 65536
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  etc_pkg::in_item_t   item,
    input  etc_pkg::cfg_t       cfg,
    input  etc_pkg::hold_wr_t   hold_wr,
    input  etc_pkg::ctrl_cmd_t  cmd,
    output etc_pkg::dp_stat_t   stat,
    output etc_pkg::out_item_t  result
);

    localparam int AW = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
    localparam int FW = $clog2(HIST_DEPTH + 1);
    localparam int LEN_CAP_INT =
        (MAX_POINTS > etc_pkg::LEN_FIELD_MAX) ? etc_pkg::LEN_FIELD_MAX : MAX_POINTS;
    localparam logic [16:0] LEN_CAP = 17'(LEN_CAP_INT);
    localparam int RST_POS_INT = (128 > HIST_DEPTH - 1) ? HIST_DEPTH - 1 : 128;
    localparam logic [24:0] RST_SKIP = 25'(RST_POS_INT + 1);
    localparam logic [AW:0] DEPTH_W = (AW + 1)'(HIST_DEPTH);
    localparam logic [AW-1:0] PTR_LAST = AW'(HIST_DEPTH - 1);
    localparam logic [FW-1:0] FILL_FULL = FW'(HIST_DEPTH);

    logic [15:0] mem [HIST_DEPTH];

    logic [AW-1:0] wr_ptr_reg;
    logic [FW-1:0] fill_reg;
    logic [15:0]   rd_data_reg;
    logic          rd_valid_reg;
    logic signed [15:0] cur_reg;
    logic          label_cur_reg;
    logic signed [15:0] prev_sample_reg;
    logic          prev_label_reg;

    logic          phase_reg;
    logic [24:0]   skip_reg;
    logic [16:0]   capture_reg;
    logic [6:0]    windows_reg;
    logic [32:0]   elapsed_reg;
    logic [15:0]   held_frac_reg;
    logic          from_level_reg;
    logic [16:0]   taken_reg;
    etc_pkg::out_item_t result_reg;

    logic [AW-1:0] pos_eff;
    logic [AW:0]   delay;
    logic [AW:0]   addr_diff;
    logic [AW-1:0] rd_addr;
    logic [16:0]   len_eff;
    logic [6:0]    nwin_eff;
    logic [24:0]   skip_reload;

    logic          allowed;
    logic          force_hit;
    logic          rise_en;
    logic          fall_en;
    logic          rise_hit;
    logic          fall_hit;
    logic          lvl_hit;
    logic          search_mode;
    logic          found_search;
    logic          trig;
    logic          trig_lvl;
    logic signed [16:0] y0_x;
    logic signed [16:0] cur_x;
    logic signed [16:0] lvl_x;
    logic [16:0]   div_num;
    logic [16:0]   div_den;
    logic          div_done;
    logic [15:0]   div_quot;
    logic          last_w;
    logic [15:0]   delayed;

    assign pos_eff = (32'(cfg.position) > 32'(HIST_DEPTH - 1)) ? PTR_LAST : AW'(cfg.position);
    assign delay   = {1'b0, pos_eff} + 1'b1;
    assign addr_diff = {1'b0, wr_ptr_reg} - delay;
    // wrap the read address for any depth, power of two or not
    assign rd_addr = ({1'b0, wr_ptr_reg} >= delay) ? addr_diff[AW-1:0]
                                                   : AW'(addr_diff + DEPTH_W);

    assign len_eff = (cfg.window_len == '0) ? 17'd1
                   : ((cfg.window_len > LEN_CAP) ? LEN_CAP : cfg.window_len);
    assign nwin_eff = (cfg.num_windows == '0) ? 7'd1 : cfg.num_windows;
    assign skip_reload = 25'(cfg.hold_off) + 25'(pos_eff) + 25'd1;

    // search decision, evaluated on registered operands
    assign y0_x  = 17'(prev_sample_reg);
    assign cur_x = 17'(cur_reg);
    assign lvl_x = 17'(cfg.level);
    assign allowed   = (windows_reg != '0) || (elapsed_reg > {1'b0, cfg.event_ticks});
    assign force_hit = {elapsed_reg, 1'b0}
                     > ({2'b00, cfg.event_ticks} + {1'b0, cfg.event_ticks, 1'b0});
    assign rise_en  = (cfg.slope_select == etc_pkg::SLOPE_RISE)
                   || (cfg.slope_select == etc_pkg::SLOPE_BOTH);
    assign fall_en  = (cfg.slope_select == etc_pkg::SLOPE_FALL)
                   || (cfg.slope_select == etc_pkg::SLOPE_BOTH);
    assign rise_hit = rise_en && (y0_x < lvl_x) && (cur_x >= lvl_x);
    assign fall_hit = fall_en && (y0_x > lvl_x) && (cur_x <= lvl_x);
    assign lvl_hit  = rise_hit || fall_hit;
    assign search_mode = (cfg.trigger_mode == etc_pkg::MODE_AUTO)
                      || (cfg.trigger_mode == etc_pkg::MODE_SEMI)
                      || (cfg.trigger_mode == etc_pkg::MODE_NORMAL);

    always_comb
    begin
        if (cfg.slope_select == etc_pkg::SLOPE_LABEL)
            found_search = prev_label_reg;
        else
            found_search = lvl_hit;
        if (!found_search && ((cfg.trigger_mode == etc_pkg::MODE_AUTO)
            || ((cfg.trigger_mode == etc_pkg::MODE_SEMI) && (windows_reg != '0))))
            found_search = force_hit;
    end

    assign trig = !phase_reg && (skip_reg == '0) && allowed
               && ((search_mode && found_search)
                   || (cfg.trigger_mode == etc_pkg::MODE_PERIODIC));
    assign trig_lvl = trig && search_mode
                   && (cfg.slope_select != etc_pkg::SLOPE_LABEL) && lvl_hit;

    // rising takes priority when both directions are enabled
    assign div_num = rise_hit ? 17'(lvl_x - y0_x) : 17'(y0_x - lvl_x);
    assign div_den = rise_hit ? 17'(cur_x - y0_x) : 17'(y0_x - cur_x);

    etc_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot)
    );

    assign last_w  = capture_reg <= 17'd1;
    assign delayed = rd_valid_reg ? rd_data_reg : 16'd0;

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
            mem[wr_ptr_reg] <= cur_reg;
        if (cmd.load)
            rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cur_reg       <= item.sample;
            label_cur_reg <= item.label_hit;
            // entries not yet written since reset read as zero
            rd_valid_reg  <= 32'(fill_reg) >= 32'(delay);
        end
        if (cmd.commit && phase_reg)
        begin
            result_reg.out_sample      <= delayed;
            result_reg.trigger_mark    <= from_level_reg && (taken_reg == 17'(pos_eff));
            result_reg.fraction        <= held_frac_reg;
            result_reg.first_of_packet <= (taken_reg == '0) && (windows_reg == nwin_eff - 7'd1);
            result_reg.last_of_window  <= last_w;
            result_reg.last_of_packet  <= last_w && (windows_reg == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg      <= '0;
            fill_reg        <= '0;
            prev_sample_reg <= '0;
            prev_label_reg  <= 1'b0;
            phase_reg       <= 1'b0;
            skip_reg        <= RST_SKIP;
            capture_reg     <= '0;
            windows_reg     <= '0;
            elapsed_reg     <= '0;
            held_frac_reg   <= '0;
            from_level_reg  <= 1'b0;
            taken_reg       <= '0;
        end
        else
        begin
            if (hold_wr.valid)
            begin
                if (skip_reg > 25'(hold_wr.value) + 25'(pos_eff) + 25'd1)
                    skip_reg <= 25'(hold_wr.value) + 25'(pos_eff) + 25'd1;
            end
            if (cmd.tick && (elapsed_reg != '1))
                elapsed_reg <= elapsed_reg + 33'd1;
            if (cmd.eval)
            begin
                if (!phase_reg && (skip_reg != '0))
                    skip_reg <= skip_reg - 25'd1;
                if (trig)
                begin
                    windows_reg    <= ((windows_reg == '0) ? nwin_eff : windows_reg) - 7'd1;
                    capture_reg    <= len_eff;
                    taken_reg      <= '0;
                    held_frac_reg  <= '0;
                    from_level_reg <= trig_lvl;
                    phase_reg      <= 1'b1;
                end
            end
            if (div_done)
                held_frac_reg <= div_quot;
            if (cmd.commit)
            begin
                if (phase_reg)
                begin
                    taken_reg <= taken_reg + 17'd1;
                    if (last_w)
                    begin
                        capture_reg <= '0;
                        phase_reg   <= 1'b0;
                        skip_reg    <= skip_reload;
                        elapsed_reg <= '0;
                    end
                    else
                        capture_reg <= capture_reg - 17'd1;
                end
                wr_ptr_reg      <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
                if (fill_reg != FILL_FULL)
                    fill_reg <= fill_reg + 1'b1;
                prev_sample_reg <= cur_reg;
                prev_label_reg  <= label_cur_reg;
            end
        end
    end

    assign stat.need_div = trig_lvl;
    assign stat.div_done = div_done;
    assign stat.emit     = phase_reg;
    assign result        = result_reg;

endmodule

// File: design/etc_ctrl.sv
// controller: sequences one sample item through evaluate, divide when needed, commit and hand-off
// depends on etc_pkg
module etc_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    input  logic               item_kind,
    input  logic               result_stall,
    input  etc_pkg::dp_stat_t  stat,
    output etc_pkg::ctrl_cmd_t cmd,
    output logic               item_stall,
    output logic               result_valid
);

    etc_pkg::etc_state_t state_reg;
    etc_pkg::etc_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= etc_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            etc_pkg::ST_IDLE:
                if (item_valid && !item_kind)
                    state_next = etc_pkg::ST_EVAL;
            etc_pkg::ST_EVAL:
                state_next = stat.need_div ? etc_pkg::ST_DIV : etc_pkg::ST_COMMIT;
            etc_pkg::ST_DIV:
                if (stat.div_done)
                    state_next = etc_pkg::ST_COMMIT;
            etc_pkg::ST_COMMIT:
                state_next = stat.emit ? etc_pkg::ST_OUT : etc_pkg::ST_IDLE;
            etc_pkg::ST_OUT:
                if (!result_stall)
                    state_next = etc_pkg::ST_IDLE;
            default:
                state_next = etc_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd          = '0;
        item_stall   = 1'b1;
        result_valid = 1'b0;
        case (state_reg)
            etc_pkg::ST_IDLE:
            begin
                item_stall = 1'b0;
                cmd.load   = item_valid && !item_kind;
                cmd.tick   = item_valid && item_kind;
            end
            etc_pkg::ST_EVAL:
            begin
                cmd.eval      = 1'b1;
                cmd.div_start = stat.need_div;
            end
            etc_pkg::ST_DIV: ;
            etc_pkg::ST_COMMIT:
                cmd.commit = 1'b1;
            etc_pkg::ST_OUT:
                result_valid = 1'b1;
            default: ;
        endcase
    end

endmodule

// File: design/edge_trigger_capture.sv
// top level of the oscilloscope edge trigger with windowed capture
// depends on etc_pkg, assert_macros.svh, etc_regs, etc_ctrl, etc_dp
//
//  channel  | handshake                      | payload
//  ---------+--------------------------------+---------------------------
//  item     | item_valid / item_stall        | etc_pkg::in_item_t
//  result   | result_valid / result_stall    | etc_pkg::out_item_t
//  config   | psel penable pwrite pready     | paddr, pwdata, prdata
//
// a tick item is taken in idle; a sample item passes through evaluate and commit,
// with a wait in the serial divider when a level crossing triggers
// a result beat is held until result_stall drops
// item_stall stays high from acceptance of a sample until it commits, or until its result beat is taken
// after reset the history reads zero through a fill count, no clearing pass
`include "assert_macros.svh"

module edge_trigger_capture
#(
    parameter int HIST_DEPTH = 256,
    parameter int MAX_POINTS = 65536
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            item_valid,
    output logic                            item_stall,
    input  etc_pkg::in_item_t               item,
    output logic                            result_valid,
    input  logic                            result_stall,
    output etc_pkg::out_item_t              result,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [etc_pkg::PADDR_WIDTH-1:0] paddr,
    input  logic [etc_pkg::PDATA_WIDTH-1:0] pwdata,
    output logic [etc_pkg::PDATA_WIDTH-1:0] prdata,
    output logic                            pready
);

    etc_pkg::cfg_t      cfg;
    etc_pkg::hold_wr_t  hold_wr;
    etc_pkg::ctrl_cmd_t cmd;
    etc_pkg::dp_stat_t  stat;

    assign pready = 1'b1;

    etc_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg),
        .hold_wr (hold_wr)
    );

    etc_ctrl u_ctrl
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_kind    (item.kind),
        .result_stall (result_stall),
        .stat         (stat),
        .cmd          (cmd),
        .item_stall   (item_stall),
        .result_valid (result_valid)
    );

    etc_dp
    #(
        .HIST_DEPTH (HIST_DEPTH),
        .MAX_POINTS (MAX_POINTS)
    )
    u_dp
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item),
        .cfg     (cfg),
        .hold_wr (hold_wr),
        .cmd     (cmd),
        .stat    (stat),
        .result  (result)
    );

    `ASSERT_IMPL(a_busy_while_result, clk, rst_n, result_valid, item_stall)
    `ASSERT_NEXT(a_one_beat_per_item, clk, rst_n, result_valid && !result_stall, !result_valid)
    `ASSERT_IMPL(a_result_after_commit, clk, rst_n, $rose(result_valid), $past(cmd.commit))

endmodule

// File: bench/tb_edge_trigger_capture.sv
// self-checking bench for edge_trigger_capture: random and directed sample/tick beats
// depends on etc_pkg and the edge_trigger_capture rtl; a scoreboard class predicts results
`timescale 1ns / 100ps

module tb_edge_trigger_capture;

    localparam int IDLE_LIMIT = 5000;
    localparam int SETTLE_CYCLES = 40;
    localparam int TARGET_ITEMS = 1450;
    localparam int QUIET_FROM = 1300;

    class capture_scoreboard;
        int unsigned mismatches;
        int unsigned results_seen;
        etc_pkg::out_item_t pending[$];

        logic [16:0] win_len;
        logic [6:0] nwin;
        logic [23:0] hold;
        logic [1:0] slope;
        logic [2:0] mode;
        logic signed [15:0] lvl;
        logic [7:0] pos;
        logic [31:0] ticks;

        logic signed [15:0] hist [256];
        logic [7:0] wp;
        bit capturing, prev_lab, lvl_found;
        longint unsigned skip, cap_left, win_left, elapsed, frac_held, taken;

        function new();
            win_len = etc_pkg::RST_WINDOW_LEN;
            nwin = etc_pkg::RST_NUM_WINDOWS;
            hold = etc_pkg::RST_HOLD_OFF;
            slope = etc_pkg::RST_SLOPE;
            mode = etc_pkg::RST_MODE;
            lvl = etc_pkg::RST_LEVEL;
            pos = etc_pkg::RST_POSITION;
            ticks = etc_pkg::RST_EVENT_TICKS;
            foreach (hist[i]) hist[i] = '0;
            wp = 0;
            capturing = 0;
            prev_lab = 0;
            lvl_found = 0;
            skip = longint'(pos) + 1;
            cap_left = 0;
            win_left = 0;
            elapsed = 0;
            frac_held = 0;
            taken = 0;
        endfunction

        function longint unsigned len_act();
            if (win_len == 0) return 1;
            return (win_len > 65536) ? 65536 : win_len;
        endfunction

        function longint unsigned nwin_act();
            return (nwin == 0) ? 1 : nwin;
        endfunction

        function longint unsigned crossing(longint num, longint den);
            longint unsigned q;
            q = (longint'(num) << 16) / den;
            return (q > 65535) ? 65535 : q;
        endfunction

        function void write_reg(etc_pkg::reg_idx_t idx, logic [31:0] v);
            longint unsigned lim;
            case (idx)
                etc_pkg::REG_WINDOW_LEN:  win_len = v[16:0];
                etc_pkg::REG_NUM_WINDOWS: nwin = v[6:0];
                etc_pkg::REG_HOLD_OFF:
                begin
                    hold = v[23:0];
                    lim = longint'(hold) + pos + 1;
                    if (skip > lim) skip = lim;
                end
                etc_pkg::REG_SLOPE:       slope = v[1:0];
                etc_pkg::REG_MODE:        mode = v[2:0];
                etc_pkg::REG_LEVEL:       lvl = v[15:0];
                etc_pkg::REG_POSITION:    pos = v[7:0];
                etc_pkg::REG_EVENT_TICKS: ticks = v;
                default: ;
            endcase
        endfunction

        function void note_input(etc_pkg::in_item_t it);
            logic signed [15:0] y0, dly;
            longint cur_l, y0_l, lv_l;
            bit allowed, found, by_level, last_w;
            longint unsigned frac;
            etc_pkg::out_item_t r;
            if (it.kind)
            begin
                if (elapsed < 64'h1_FFFF_FFFF) elapsed++;
                return;
            end
            y0 = hist[wp - 8'd1];
            dly = hist[wp - pos - 8'd1];
            cur_l = it.sample;
            y0_l = y0;
            lv_l = lvl;
            if (!capturing)
            begin
                if (skip != 0)
                    skip--;
                else
                begin
                    allowed = (win_left != 0) || (elapsed > ticks);
                    found = 0;
                    by_level = 0;
                    frac = 0;
                    if (allowed && mode <= etc_pkg::MODE_NORMAL)
                    begin
                        if (slope == etc_pkg::SLOPE_LABEL)
                            found = prev_lab;
                        else if ((slope == etc_pkg::SLOPE_RISE || slope == etc_pkg::SLOPE_BOTH)
                                 && y0_l < lv_l && cur_l >= lv_l)
                        begin
                            found = 1;
                            by_level = 1;
                            frac = crossing(lv_l - y0_l, cur_l - y0_l);
                        end
                        else if ((slope == etc_pkg::SLOPE_FALL || slope == etc_pkg::SLOPE_BOTH)
                                 && y0_l > lv_l && cur_l <= lv_l)
                        begin
                            found = 1;
                            by_level = 1;
                            frac = crossing(y0_l - lv_l, y0_l - cur_l);
                        end
                        if (!found && (mode == etc_pkg::MODE_AUTO
                                       || (mode == etc_pkg::MODE_SEMI && win_left != 0)))
                            found = (2 * elapsed) > (3 * longint'(ticks));
                    end
                    else if (allowed && mode == etc_pkg::MODE_PERIODIC)
                        found = 1;
                    if (found)
                    begin
                        if (win_left == 0) win_left = nwin_act();
                        win_left--;
                        cap_left = len_act();
                        taken = 0;
                        frac_held = frac;
                        lvl_found = by_level;
                        capturing = 1;
                    end
                end
            end
            if (capturing)
            begin
                last_w = cap_left <= 1;
                r.out_sample = dly;
                r.trigger_mark = lvl_found && taken == pos;
                r.fraction = frac_held[15:0];
                r.first_of_packet = taken == 0 && win_left == nwin_act() - 1;
                r.last_of_window = last_w;
                r.last_of_packet = last_w && win_left == 0;
                pending.insert(pending.size(), r);
                taken++;
                if (cap_left != 0) cap_left--;
                if (last_w)
                begin
                    cap_left = 0;
                    capturing = 0;
                    skip = longint'(hold) + pos + 1;
                    elapsed = 0;
                end
            end
            hist[wp] = it.sample;
            wp = wp + 8'd1;
            prev_lab = it.label_hit;
        endfunction

        task report(string what, longint unsigned exp_v, longint unsigned got_v);
            $display("mismatch on result %0d: %s expected %0h got %0h",
                     results_seen, what, exp_v, got_v);
            mismatches++;
        endtask

        task check_result(etc_pkg::out_item_t got);
            etc_pkg::out_item_t e;
            if (pending.size() == 0)
            begin
                report("unexpected beat", 0, 1);
                results_seen++;
                return;
            end
            e = pending.pop_front();
            if (got.out_sample !== e.out_sample)
                report("out_sample", e.out_sample, got.out_sample);
            if (got.trigger_mark !== e.trigger_mark)
                report("trigger_mark", e.trigger_mark, got.trigger_mark);
            if (got.fraction !== e.fraction)
                report("fraction", e.fraction, got.fraction);
            if (got.first_of_packet !== e.first_of_packet)
                report("first_of_packet", e.first_of_packet, got.first_of_packet);
            if (got.last_of_window !== e.last_of_window)
                report("last_of_window", e.last_of_window, got.last_of_window);
            if (got.last_of_packet !== e.last_of_packet)
                report("last_of_packet", e.last_of_packet, got.last_of_packet);
            results_seen++;
        endtask
    endclass

    logic clk;
    logic rst_n;
    logic item_valid;
    logic item_stall;
    etc_pkg::in_item_t item;
    logic result_valid;
    logic result_stall = 1'b0;
    etc_pkg::out_item_t result;
    logic psel, penable, pwrite;
    logic [etc_pkg::PADDR_WIDTH-1:0] paddr;
    logic [etc_pkg::PDATA_WIDTH-1:0] pwdata;
    logic [etc_pkg::PDATA_WIDTH-1:0] prdata;
    logic pready;

    capture_scoreboard sb = new();
    int unsigned sent_items, sent_ticks, phases, idle_cycles;
    bit quiet;
    int stall_left;

    edge_trigger_capture dut (
        .clk(clk), .rst_n(rst_n),
        .item_valid(item_valid), .item_stall(item_stall), .item(item),
        .result_valid(result_valid), .result_stall(result_stall), .result(result),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial
    begin
        clk = 0;
        forever #4 clk = ~clk;
    end

    // result side: check accepted beats, stall in random bursts
    always @(posedge clk)
    begin
        int nxt;
        if (rst_n && result_valid && !result_stall)
            sb.check_result(result);
        nxt = 0;
        if (!quiet)
        begin
            if (stall_left > 0)
            begin
                stall_left--;
                nxt = 1;
            end
            else if ($urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(0, 18);
                nxt = 1;
            end
        end
        result_stall <= nxt[0];
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item_valid && !item_stall) || (result_valid && !result_stall) || psel)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("timeout: no beat for %0d cycles", IDLE_LIMIT);
                $display("tb: failure");
                $finish;
            end
        end
    end

    task write_reg(etc_pkg::reg_idx_t idx, logic [31:0] v);
        psel <= 1;
        penable <= 0;
        pwrite <= 1;
        paddr <= etc_pkg::PADDR_WIDTH'(idx) << 2;
        pwdata <= v;
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        psel <= 0;
        penable <= 0;
        sb.write_reg(idx, v);
        @(posedge clk);
    endtask

    // drain everything outstanding before touching registers
    task settle();
        item_valid <= 0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task send(bit is_tick, logic signed [15:0] s, bit lab);
        int gap;
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 19);
            item_valid <= 0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1;
        item <= '{kind: is_tick, sample: s, label_hit: lab};
        do @(posedge clk); while (item_stall);
        sb.note_input('{kind: is_tick, sample: s, label_hit: lab});
        if (is_tick) sent_ticks++;
        else sent_items++;
    endtask

    function logic signed [15:0] near_level(logic signed [15:0] lv);
        int v;
        case ($urandom_range(0, 5))
            0: return 16'($urandom);
            1: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            default:
            begin
                v = int'(lv) + $urandom_range(0, 80) - 40;
                if (v > 32767) v = 32767;
                if (v < -32768) v = -32768;
                return v[15:0];
            end
        endcase
    endfunction

    task random_config();
        int r;
        r = $urandom_range(0, 9);
        write_reg(etc_pkg::REG_WINDOW_LEN, r == 0 ? 32'd0 : (r == 1 ? $urandom_range(13, 40)
                                                                 : $urandom_range(1, 12)));
        r = $urandom_range(0, 9);
        write_reg(etc_pkg::REG_NUM_WINDOWS,
                  r == 0 ? 32'd0 : (r == 1 ? 32'd127 : $urandom_range(1, 4)));
        write_reg(etc_pkg::REG_POSITION, $urandom_range(0, 9) == 0 ? $urandom_range(16, 255)
                                                                   : $urandom_range(0, 15));
        write_reg(etc_pkg::REG_HOLD_OFF, $urandom_range(0, 8));
        write_reg(etc_pkg::REG_SLOPE, $urandom_range(0, 3));
        write_reg(etc_pkg::REG_MODE, $urandom_range(0, 9) == 0 ? $urandom_range(4, 7)
                                                               : $urandom_range(0, 3));
        write_reg(etc_pkg::REG_LEVEL,
                  $urandom_range(0, 4) == 0 ? $urandom : $urandom_range(0, 400) - 200);
        write_reg(etc_pkg::REG_EVENT_TICKS, $urandom_range(1, 12));
    endtask

    initial
    begin
        bit tk;
        int len;
        rst_n = 0;
        item_valid = 0;
        item = '0;
        psel = 0;
        penable = 0;
        pwrite = 0;
        paddr = '0;
        pwdata = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: both slopes at level zero, extremes, exact-level hit, labels
        write_reg(etc_pkg::REG_WINDOW_LEN, 3);
        write_reg(etc_pkg::REG_NUM_WINDOWS, 2);
        write_reg(etc_pkg::REG_POSITION, 1);
        write_reg(etc_pkg::REG_HOLD_OFF, 0);
        write_reg(etc_pkg::REG_SLOPE, 32'(etc_pkg::SLOPE_BOTH));
        write_reg(etc_pkg::REG_MODE, 32'(etc_pkg::MODE_NORMAL));
        write_reg(etc_pkg::REG_LEVEL, 0);
        write_reg(etc_pkg::REG_EVENT_TICKS, 1);
        repeat (3) send(1, 16'sh7fff, 1);
        send(0, -16'sd32768, 0);
        send(0, 16'sh7fff, 1);
        send(0, -16'sd5, 0);
        send(0, 16'sd0, 0);
        send(0, 16'sd100, 1);
        send(0, -16'sd100, 0);
        send(0, 16'sd3, 1);
        send(0, -16'sd1, 0);
        send(0, 16'sd1, 0);
        send(0, -16'sd32768, 0);
        send(0, 16'sh7fff, 0);
        send(0, 16'sd0, 0);
        settle();
        write_reg(etc_pkg::REG_SLOPE, 32'(etc_pkg::SLOPE_LABEL));
        write_reg(etc_pkg::REG_MODE, 32'(etc_pkg::MODE_AUTO));
        repeat (4) send(1, 0, 0);
        for (int i = 0; i < 8; i++) send(0, 16'($urandom), i[0]);
        settle();

        // extreme register values, block kept from triggering
        write_reg(etc_pkg::REG_MODE, 7);
        write_reg(etc_pkg::REG_WINDOW_LEN, 32'h1ffff);
        write_reg(etc_pkg::REG_NUM_WINDOWS, 127);
        write_reg(etc_pkg::REG_HOLD_OFF, 32'hffffff);
        write_reg(etc_pkg::REG_POSITION, 255);
        write_reg(etc_pkg::REG_LEVEL, 32'h8000);
        write_reg(etc_pkg::REG_EVENT_TICKS, 32'hffffffff);
        for (int i = 0; i < 10; i++) send(i[0], 16'($urandom), 1'($urandom_range(0, 1)));
        settle();
        write_reg(etc_pkg::REG_LEVEL, 32'h7fff);
        write_reg(etc_pkg::REG_HOLD_OFF, 0);
        settle();

        while (sent_items + sent_ticks < TARGET_ITEMS)
        begin
            random_config();
            phases++;
            len = $urandom_range(40, 120);
            for (int i = 0; i < len; i++)
            begin
                if (sent_items + sent_ticks >= QUIET_FROM) quiet = 1;
                tk = $urandom_range(0, 3) == 0;
                send(tk, near_level(sb.lvl), $urandom_range(0, 3) == 0);
            end
            settle();
        end

        item_valid <= 0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("sent %0d samples and %0d ticks over %0d random settings",
                 sent_items, sent_ticks, phases);
        $display("checked %0d result beats, %0d mismatches", sb.results_seen, sb.mismatches);
        if (sb.mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
